FILE: hdl/swmv_pkg.sv
`default_nettype none

package swmv_pkg;

	// Fixed widths of the register and result fields.
	localparam int N_W        = 9;
	localparam int MEAN_W     = 24;
	localparam int VAR_W      = 39;
	localparam int FRAC_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Register map of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_ENABLE = 2'd1;

	// Window size after reset, before it is limited to the store depth.
	localparam int WINDOW_SIZE_INIT = 256;

	// Limits of the signed 24-bit mean.
	localparam logic [MEAN_W-1:0] MEAN_MAX = 24'h7F_FFFF;
	localparam logic [MEAN_W-1:0] MEAN_MIN = 24'h80_0000;

endpackage

`default_nettype wire

FILE: hdl/swmv_ram.sv
`default_nettype none

module swmv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/swmv_mul.sv
`default_nettype none

// Shift-and-add multiplier: one multiplier bit is retired per cycle, and
// the run ends as soon as no set bit is left.
module swmv_mul #(
	parameter int A_W = 48,
	parameter int B_W = 24
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [A_W-1:0] a,
	input  wire logic [B_W-1:0] b,
	output logic                done,
	output logic      [A_W-1:0] prod
);

	logic           run_q;
	logic [A_W-1:0] a_q;
	logic [A_W-1:0] acc_q;
	logic [B_W-1:0] b_q;

	assign done = run_q && (b_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (done) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (run_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[A_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[B_W-1:1]};
		end
	end

endmodule

`default_nettype wire

FILE: hdl/swmv_div.sv
`default_nettype none

// Restoring divider: the dividend leaves the top of a shift register one
// bit per cycle while quotient bits enter at the bottom.
module swmv_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 18,
	localparam int C_W = $clog2(NUM_W + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] numer,
	input  wire logic [C_W-1:0]   steps,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  done,
	output logic      [NUM_W-1:0] quot
);

	logic             run_q;
	logic [C_W-1:0]   cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = run_q && (cnt_q == '0);
	assign quot  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (done) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			cnt_q <= steps;
			den_q <= divisor;
			rem_q <= '0;
		end else if (run_q && (cnt_q != '0)) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sliding_window_mean_variance.sv
`default_nettype none

// Sliding-window mean and sample variance. Each accepted item carries one
// signed sample; the block keeps the last window_size samples in a ring
// memory together with an exact running sum and sum of squares, and answers
// every item with one result: mean_q8 = trunc(256*sum/n), and, while
// variance_enable is set and n > 1, variance_q8 =
// trunc(256*(n*sumsq - sum^2)/(n*(n-1))), where n (also on count) is the
// number of samples now in the window. Items are processed one at a time by
// a sequencer around a shared shift-and-add multiplier (one multiplier bit
// per cycle) and a shared restoring divider (one quotient bit per cycle).
// For each item the sequencer squares the sample leaving the window (once
// the window is full) and the new sample, then divides for the mean; while
// the variance is enabled and n > 1 it then forms the n*sumsq, sum^2 and
// n*(n-1) products and divides once more.
// The multiplier stops early once no set multiplier bit is left, so small
// values finish sooner. A finished result waits in an output register, so
// the next item is already taken while the previous result is stalled.
// Writing window_size empties the window; configuration writes are meant
// to arrive only while no item is in progress.
module sliding_window_mean_variance
	import swmv_pkg::*;
#(
	parameter int WINDOW_DEPTH = 256,
	parameter int SAMPLE_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,

	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed      [MEAN_W-1:0]      mean_q8,
	output logic             [VAR_W-1:0]       variance_q8,
	output logic                               variance_valid,
	output logic             [N_W-1:0]         count,

	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic        [CFG_DATA_W-1:0]  cfg_data
);

	// Widths that follow from the parameters.
	localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int MAG_W  = SAMPLE_BITS + IDX_W;
	localparam int SUM_W  = MAG_W + 1;
	localparam int SQ_W   = 2 * SAMPLE_BITS + IDX_W - 1;
	localparam int P_W    = (N_W + SQ_W > 2 * MAG_W) ? N_W + SQ_W : 2 * MAG_W;
	localparam int DV_W   = P_W + FRAC_W;
	localparam int MQ_W   = MAG_W + FRAC_W;
	localparam int DS_W   = 2 * N_W;
	localparam int CNT_W  = $clog2(DV_W + 1);
	localparam int CMP_W  = (IDX_W + 1 > N_W) ? IDX_W + 1 : N_W;
	localparam int CMPM_W = (MQ_W > MEAN_W + 1) ? MQ_W : MEAN_W + 1;
	localparam int QX_W   = (DV_W > VAR_W + 1) ? DV_W : VAR_W + 1;
	localparam int SIZE_INIT_I =
		(WINDOW_DEPTH < WINDOW_SIZE_INIT) ? WINDOW_DEPTH : WINDOW_SIZE_INIT;
	localparam logic [N_W-1:0] SIZE_INIT = N_W'(SIZE_INIT_I);

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FETCH  = 4'd1;
	localparam logic [3:0] S_SQ_OLD = 4'd2;
	localparam logic [3:0] S_SQ_NEW = 4'd3;
	localparam logic [3:0] S_MEAN   = 4'd4;
	localparam logic [3:0] S_NSQ    = 4'd5;
	localparam logic [3:0] S_SUM2   = 4'd6;
	localparam logic [3:0] S_NN1    = 4'd7;
	localparam logic [3:0] S_VDIV   = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q;

	// Window state and configuration.
	logic [IDX_W-1:0]        wr_idx_q;
	logic                    wrapped_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sumsq_q;
	logic [N_W-1:0]          size_q;
	logic                    ven_q;

	// Per-item working registers.
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic [IDX_W-1:0]              slot_q;
	logic [N_W-1:0]                n_q;
	logic [P_W-1:0]                nsq_q;
	logic [P_W-1:0]                sq2_q;
	logic [MEAN_W-1:0]             mean_res_q;
	logic [VAR_W-1:0]              var_res_q;

	// Output register.
	logic              out_valid_q;
	logic [MEAN_W-1:0] mean_o_q;
	logic [VAR_W-1:0]  var_o_q;
	logic              vvalid_o_q;
	logic [N_W-1:0]    count_o_q;

	// Shared units and memory.
	logic                   mul_start;
	logic [P_W-1:0]         mul_a;
	logic [MAG_W-1:0]       mul_b;
	logic                   mul_done;
	logic [P_W-1:0]         mul_prod;
	logic                   div_start;
	logic [DV_W-1:0]        div_numer;
	logic [CNT_W-1:0]       div_steps;
	logic [DS_W-1:0]        div_den;
	logic                   div_done;
	logic [DV_W-1:0]        div_quot;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [IDX_W-1:0]       ram_raddr;

	// Derived values.
	logic                   in_acc;
	logic                   load_out;
	logic [SAMPLE_BITS-1:0] x_mag;
	logic [SAMPLE_BITS-1:0] rd_mag;
	logic [SUM_W-1:0]       sum_abs;
	logic [MAG_W-1:0]       sum_mag;
	logic [CMP_W-1:0]       nxt_cmp;
	logic                   at_end;
	logic [N_W-1:0]         n_next;
	logic                   var_go;
	logic [P_W-1:0]         diff_p;
	logic [CMPM_W-1:0]      mq_ext;
	logic [MEAN_W-1:0]      mean_calc;
	logic [QX_W-1:0]        quot_ext;
	logic                   var_sat;
	logic [N_W-1:0]         size_clamped;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Magnitudes of the new sample, of the sample leaving the window and of
	// the running sum; all squarings and divisions work on magnitudes.
	assign x_mag   = x_q[SAMPLE_BITS-1] ? (~x_q + 1'b1) : x_q;
	assign rd_mag  = ram_rdata[SAMPLE_BITS-1] ? (~ram_rdata + 1'b1) : ram_rdata;
	assign sum_abs = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign sum_mag = sum_abs[MAG_W-1:0];

	// Write position of the next item; a position beyond the window wraps to
	// the start of the store.
	assign ram_raddr = (CMP_W'(wr_idx_q) >= CMP_W'(size_q)) ? '0 : wr_idx_q;

	// Window bookkeeping after the current sample has been written.
	assign nxt_cmp = CMP_W'(slot_q) + 1'b1;
	assign at_end  = (nxt_cmp >= CMP_W'(size_q));
	assign n_next  = (at_end || wrapped_q) ? size_q : N_W'(nxt_cmp);

	assign var_go = ven_q && (n_q > N_W'(1));
	assign diff_p = nsq_q - sq2_q;

	// Mean: divide the magnitude, then restore the sign and saturate. A
	// negative mean may reach one step further than a positive one.
	assign mq_ext = CMPM_W'(div_quot[MQ_W-1:0]);
	always_comb begin
		if (!sum_q[SUM_W-1]) begin
			if (mq_ext > CMPM_W'(MEAN_MAX)) begin
				mean_calc = MEAN_MAX;
			end else begin
				mean_calc = mq_ext[MEAN_W-1:0];
			end
		end else begin
			if (mq_ext > CMPM_W'(MEAN_MIN)) begin
				mean_calc = MEAN_MIN;
			end else begin
				mean_calc = ~mq_ext[MEAN_W-1:0] + 1'b1;
			end
		end
	end

	// Variance saturates when any quotient bit lands above the result field.
	assign quot_ext = QX_W'(div_quot);
	assign var_sat  = |quot_ext[QX_W-1:VAR_W];

	// A window size of zero acts as one, and sizes beyond the store are
	// limited to its depth.
	always_comb begin
		if (cfg_data == '0) begin
			size_clamped = N_W'(1);
		end else if (32'(cfg_data) > WINDOW_DEPTH) begin
			size_clamped = N_W'(WINDOW_DEPTH);
		end else begin
			size_clamped = cfg_data;
		end
	end

	// Operand selection for the shared multiplier and divider. Each start
	// comes in the cycle in which the previous step of the item finishes.
	always_comb begin
		mul_start = 1'b0;
		mul_a     = P_W'(x_mag);
		mul_b     = MAG_W'(x_mag);
		div_start = 1'b0;
		div_numer = {sum_mag, {FRAC_W{1'b0}}, {(DV_W - MQ_W){1'b0}}};
		div_steps = CNT_W'(MQ_W);
		div_den   = DS_W'(n_next);
		case (state_q)
			S_FETCH: begin
				mul_start = 1'b1;
				if (wrapped_q) begin
					mul_a = P_W'(rd_mag);
					mul_b = MAG_W'(rd_mag);
				end
			end
			S_SQ_OLD: begin
				mul_start = mul_done;
			end
			S_SQ_NEW: begin
				div_start = mul_done;
			end
			S_MEAN: begin
				mul_start = div_done && var_go;
				mul_a     = P_W'(sumsq_q);
				mul_b     = MAG_W'(n_q);
			end
			S_NSQ: begin
				mul_start = mul_done;
				mul_a     = P_W'(sum_mag);
				mul_b     = sum_mag;
			end
			S_SUM2: begin
				mul_start = mul_done;
				mul_a     = P_W'(n_q);
				mul_b     = MAG_W'(n_q - 1'b1);
			end
			S_NN1: begin
				div_start = mul_done;
				div_numer = {diff_p, {FRAC_W{1'b0}}};
				div_steps = CNT_W'(DV_W);
				div_den   = mul_prod[DS_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Sequencer, window state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_idx_q    <= '0;
			wrapped_q   <= 1'b0;
			sum_q       <= '0;
			sumsq_q     <= '0;
			size_q      <= SIZE_INIT;
			ven_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					// The new sample enters the sum at once; the leaving
					// one is taken out once its square is known.
					sum_q   <= sum_q + SUM_W'(x_q);
					state_q <= wrapped_q ? S_SQ_OLD : S_SQ_NEW;
				end
				S_SQ_OLD: begin
					if (mul_done) begin
						sum_q   <= sum_q - SUM_W'(old_q);
						sumsq_q <= sumsq_q - mul_prod[SQ_W-1:0];
						state_q <= S_SQ_NEW;
					end
				end
				S_SQ_NEW: begin
					if (mul_done) begin
						sumsq_q <= sumsq_q + mul_prod[SQ_W-1:0];
						if (at_end) begin
							wr_idx_q  <= '0;
							wrapped_q <= 1'b1;
						end else begin
							wr_idx_q <= nxt_cmp[IDX_W-1:0];
						end
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (div_done) begin
						state_q <= var_go ? S_NSQ : S_DONE;
					end
				end
				S_NSQ: begin
					if (mul_done) begin
						state_q <= S_SUM2;
					end
				end
				S_SUM2: begin
					if (mul_done) begin
						state_q <= S_NN1;
					end
				end
				S_NN1: begin
					if (mul_done) begin
						state_q <= S_VDIV;
					end
				end
				S_VDIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Any write of window_size starts an empty window.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_SIZE: begin
						size_q    <= size_clamped;
						wr_idx_q  <= '0;
						wrapped_q <= 1'b0;
						sum_q     <= '0;
						sumsq_q   <= '0;
					end
					REG_VARIANCE_ENABLE: begin
						ven_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers of the item in progress and of the output stage.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= sample;
			slot_q <= ram_raddr;
		end
		if (state_q == S_FETCH) begin
			old_q <= ram_rdata;
		end
		if ((state_q == S_SQ_NEW) && mul_done) begin
			n_q <= n_next;
		end
		if ((state_q == S_MEAN) && div_done) begin
			mean_res_q <= mean_calc;
			var_res_q  <= '0;
		end
		if ((state_q == S_NSQ) && mul_done) begin
			nsq_q <= mul_prod;
		end
		if ((state_q == S_SUM2) && mul_done) begin
			sq2_q <= mul_prod;
		end
		if ((state_q == S_VDIV) && div_done) begin
			var_res_q <= var_sat ? {VAR_W{1'b1}} : quot_ext[VAR_W-1:0];
		end
		if (load_out) begin
			mean_o_q   <= mean_res_q;
			var_o_q    <= var_res_q;
			vvalid_o_q <= ven_q;
			count_o_q  <= n_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign mean_q8        = mean_o_q;
	assign variance_q8    = var_o_q;
	assign variance_valid = vvalid_o_q;
	assign count          = count_o_q;

	// The sample store; the old sample at the write slot is read in the
	// accepting cycle and the new one written over it in the next.
	swmv_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (state_q == S_FETCH),
		.waddr(slot_q),
		.wdata(x_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	swmv_mul #(
		.A_W(P_W),
		.B_W(MAG_W)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	swmv_div #(
		.NUM_W(DV_W),
		.DEN_W(DS_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.steps  (div_steps),
		.divisor(div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// The write position always stays inside the configured window.
	assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(wr_idx_q) < CMP_W'(size_q))
		else $error("write position outside the window");

	// A result without a variance carries a zero variance field.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !vvalid_o_q |-> var_o_q == '0)
		else $error("variance reported while disabled");

	// A delivered result always counts at least one and at most size samples.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_o_q != '0) && (count_o_q <= size_q))
		else $error("result count out of range");

	// A finished item waits in its last state while the output is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && out_valid_q && out_stall |=> state_q == S_DONE)
		else $error("finished item left while output was blocked");

endmodule

`default_nettype wire
